[design/hllc_pkg.sv]
// Shared types, register-file map and microprogram for the HLLC interface solver.
`default_nettype none
package hllc_pkg;

  typedef logic signed [63:0] fix_t;

  typedef struct packed {
    logic side;
    fix_t density;
    fix_t pressure;
    fix_t total_energy;
    fix_t sound_speed;
    fix_t vel_x;
    fix_t vel_y;
    fix_t vel_z;
    fix_t normal_x;
    fix_t normal_y;
    fix_t normal_z;
  } in_item_t;

  typedef struct packed {
    fix_t star_density;
    fix_t star_vel_x;
    fix_t star_vel_y;
    fix_t star_vel_z;
    fix_t star_pressure;
    fix_t star_energy;
    logic [1:0] region;
    logic div_fault;
  } out_item_t;

  typedef struct packed {
    in_item_t rgt;
    fix_t l_density;
    fix_t l_pressure;
    fix_t l_energy;
    fix_t l_sound;
    fix_t l_vx;
    fix_t l_vy;
    fix_t l_vz;
  } q_entry_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_HALF, OP_MAX0, OP_MIN, OP_END
  } op_t;

  typedef enum logic [2:0] {
    FC_NONE, FC_S, FC_R, FC_E, FC_P
  } fc_t;

  typedef struct packed {
    op_t op;
    fc_t fc;
    logic d3;
    logic [5:0] dst;
    logic ka;
    logic [5:0] a;
    logic kb;
    logic [5:0] b;
  } instr_t;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_LSTAR = 2'd1;
  localparam logic [1:0] REG_RSTAR = 2'd2;
  localparam logic [1:0] REG_RIGHT = 2'd3;

  // register file map; right block mirrors left block at K_OFS
  localparam logic [5:0] X_ZERO = 6'd0;
  localparam logic [5:0] X_LR   = 6'd1;
  localparam logic [5:0] X_LP   = 6'd2;
  localparam logic [5:0] X_LE   = 6'd3;
  localparam logic [5:0] X_LC   = 6'd4;
  localparam logic [5:0] X_LV0  = 6'd5;
  localparam logic [5:0] X_LV1  = 6'd6;
  localparam logic [5:0] X_LV2  = 6'd7;
  localparam logic [5:0] X_LU   = 6'd8;
  localparam logic [5:0] X_LS   = 6'd9;
  localparam logic [5:0] X_RR   = 6'd10;
  localparam logic [5:0] X_RP   = 6'd11;
  localparam logic [5:0] X_RE   = 6'd12;
  localparam logic [5:0] X_RC   = 6'd13;
  localparam logic [5:0] X_RV0  = 6'd14;
  localparam logic [5:0] X_RV1  = 6'd15;
  localparam logic [5:0] X_RV2  = 6'd16;
  localparam logic [5:0] X_RU   = 6'd17;
  localparam logic [5:0] X_RS   = 6'd18;
  localparam logic [5:0] X_N0   = 6'd19;
  localparam logic [5:0] X_N1   = 6'd20;
  localparam logic [5:0] X_N2   = 6'd21;
  localparam logic [5:0] X_SS   = 6'd22;
  localparam logic [5:0] X_DL   = 6'd23;
  localparam logic [5:0] X_DR   = 6'd24;
  localparam logic [5:0] X_SU   = 6'd25;
  localparam logic [5:0] X_SU2  = 6'd26;
  localparam logic [5:0] X_T1   = 6'd27;
  localparam logic [5:0] X_T2   = 6'd28;
  localparam logic [5:0] X_T3   = 6'd29;
  localparam logic [5:0] X_BR   = 6'd30;
  localparam logic [5:0] X_RHO  = 6'd31;
  localparam logic [5:0] X_EST  = 6'd32;
  localparam logic [5:0] X_PST  = 6'd33;
  localparam logic [5:0] X_VS0  = 6'd34;
  localparam logic [5:0] X_VS1  = 6'd35;
  localparam logic [5:0] X_VS2  = 6'd36;
  localparam logic [5:0] X_SUM  = 6'd37;
  localparam logic [5:0] X_RA   = 6'd38;
  localparam logic [5:0] X_RCL  = 6'd39;
  localparam logic [5:0] X_RCR  = 6'd40;
  localparam logic [5:0] X_RCLR = 6'd41;
  localparam logic [5:0] X_DU   = 6'd42;
  localparam logic [5:0] X_LIM  = 6'd43;
  localparam logic [5:0] X_NUM  = 6'd44;
  localparam logic [5:0] X_DEN  = 6'd45;
  localparam logic [5:0] K_OFS  = 6'd9;

  localparam logic [6:0] PC_END_A = 7'd27;
  localparam logic [6:0] PC_STAR  = 7'd28;
  localparam logic [6:0] PC_END_B = 7'd46;
  localparam logic [6:0] PC_LIM   = 7'd47;
  localparam logic [6:0] PC_PLAIN = 7'd72;

  function automatic instr_t mk(op_t op, fc_t fc, logic d3, logic [5:0] dst,
                                logic ka, logic [5:0] a, logic kb, logic [5:0] b);
    instr_t i;
    i.op = op; i.fc = fc; i.d3 = d3; i.dst = dst;
    i.ka = ka; i.a = a; i.kb = kb; i.b = b;
    return i;
  endfunction

  function automatic instr_t prog(logic [6:0] pc);
    instr_t i;
    case (pc)
      7'd0:  i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_N0, 1'b0, X_LV0);
      7'd1:  i = mk(OP_MUL, FC_NONE, 1'b0, X_T2, 1'b0, X_N1, 1'b0, X_LV1);
      7'd2:  i = mk(OP_ADD, FC_NONE, 1'b0, X_T3, 1'b0, X_T1, 1'b0, X_T2);
      7'd3:  i = mk(OP_MUL, FC_NONE, 1'b1, X_T1, 1'b0, X_N2, 1'b0, X_LV2);
      7'd4:  i = mk(OP_ADD, FC_NONE, 1'b1, X_T3, 1'b0, X_T3, 1'b0, X_T1);
      7'd5:  i = mk(OP_SUB, FC_NONE, 1'b0, X_LU, 1'b0, X_ZERO, 1'b0, X_T3);
      7'd6:  i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_N0, 1'b0, X_RV0);
      7'd7:  i = mk(OP_MUL, FC_NONE, 1'b0, X_T2, 1'b0, X_N1, 1'b0, X_RV1);
      7'd8:  i = mk(OP_ADD, FC_NONE, 1'b0, X_T3, 1'b0, X_T1, 1'b0, X_T2);
      7'd9:  i = mk(OP_MUL, FC_NONE, 1'b1, X_T1, 1'b0, X_N2, 1'b0, X_RV2);
      7'd10: i = mk(OP_ADD, FC_NONE, 1'b1, X_T3, 1'b0, X_T3, 1'b0, X_T1);
      7'd11: i = mk(OP_SUB, FC_NONE, 1'b0, X_RU, 1'b0, X_ZERO, 1'b0, X_T3);
      7'd12: i = mk(OP_SUB, FC_NONE, 1'b0, X_LS, 1'b0, X_LU, 1'b0, X_LC);
      7'd13: i = mk(OP_ADD, FC_NONE, 1'b0, X_RS, 1'b0, X_RU, 1'b0, X_RC);
      7'd14: i = mk(OP_SUB, FC_NONE, 1'b0, X_DR, 1'b0, X_RS, 1'b0, X_RU);
      7'd15: i = mk(OP_SUB, FC_NONE, 1'b0, X_DL, 1'b0, X_LU, 1'b0, X_LS);
      7'd16: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_RR, 1'b0, X_RU);
      7'd17: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_T1, 1'b0, X_DR);
      7'd18: i = mk(OP_MUL, FC_NONE, 1'b0, X_T2, 1'b0, X_LR, 1'b0, X_LU);
      7'd19: i = mk(OP_MUL, FC_NONE, 1'b0, X_T2, 1'b0, X_T2, 1'b0, X_DL);
      7'd20: i = mk(OP_ADD, FC_NONE, 1'b0, X_NUM, 1'b0, X_T1, 1'b0, X_T2);
      7'd21: i = mk(OP_ADD, FC_NONE, 1'b0, X_NUM, 1'b0, X_NUM, 1'b0, X_LP);
      7'd22: i = mk(OP_SUB, FC_NONE, 1'b0, X_NUM, 1'b0, X_NUM, 1'b0, X_RP);
      7'd23: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_RR, 1'b0, X_DR);
      7'd24: i = mk(OP_MUL, FC_NONE, 1'b0, X_T2, 1'b0, X_LR, 1'b0, X_DL);
      7'd25: i = mk(OP_ADD, FC_NONE, 1'b0, X_DEN, 1'b0, X_T1, 1'b0, X_T2);
      7'd26: i = mk(OP_DIV, FC_S, 1'b0, X_SS, 1'b0, X_NUM, 1'b0, X_DEN);
      7'd28: i = mk(OP_SUB, FC_NONE, 1'b0, X_SU, 1'b1, X_LS, 1'b1, X_LU);
      7'd29: i = mk(OP_SUB, FC_NONE, 1'b0, X_SU2, 1'b0, X_SS, 1'b1, X_LU);
      7'd30: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b1, X_LR, 1'b0, X_SU);
      7'd31: i = mk(OP_SUB, FC_NONE, 1'b0, X_T2, 1'b1, X_LS, 1'b0, X_SS);
      7'd32: i = mk(OP_DIV, FC_R, 1'b0, X_RHO, 1'b0, X_T1, 1'b0, X_T2);
      7'd33: i = mk(OP_DIV, FC_E, 1'b0, X_T1, 1'b1, X_LP, 1'b1, X_LR);
      7'd34: i = mk(OP_DIV, FC_E, 1'b0, X_T1, 1'b0, X_T1, 1'b0, X_SU);
      7'd35: i = mk(OP_ADD, FC_NONE, 1'b0, X_BR, 1'b0, X_SS, 1'b0, X_T1);
      7'd36: i = mk(OP_DIV, FC_E, 1'b0, X_T2, 1'b1, X_LE, 1'b1, X_LR);
      7'd37: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_SU2, 1'b0, X_BR);
      7'd38: i = mk(OP_ADD, FC_NONE, 1'b0, X_BR, 1'b0, X_T2, 1'b0, X_T1);
      7'd39: i = mk(OP_MUL, FC_NONE, 1'b0, X_EST, 1'b0, X_RHO, 1'b0, X_BR);
      7'd40: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_N0, 1'b0, X_SU2);
      7'd41: i = mk(OP_SUB, FC_NONE, 1'b0, X_VS0, 1'b1, X_LV0, 1'b0, X_T1);
      7'd42: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_N1, 1'b0, X_SU2);
      7'd43: i = mk(OP_SUB, FC_NONE, 1'b0, X_VS1, 1'b1, X_LV1, 1'b0, X_T1);
      7'd44: i = mk(OP_MUL, FC_NONE, 1'b1, X_T1, 1'b0, X_N2, 1'b0, X_SU2);
      7'd45: i = mk(OP_SUB, FC_NONE, 1'b1, X_VS2, 1'b1, X_LV2, 1'b0, X_T1);
      7'd47: i = mk(OP_ADD, FC_NONE, 1'b0, X_SUM, 1'b0, X_LR, 1'b0, X_RR);
      7'd48: i = mk(OP_ADD, FC_NONE, 1'b0, X_T1, 1'b0, X_LR, 1'b0, X_LR);
      7'd49: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_T1, 1'b0, X_RR);
      7'd50: i = mk(OP_DIV, FC_P, 1'b0, X_RA, 1'b0, X_T1, 1'b0, X_SUM);
      7'd51: i = mk(OP_MUL, FC_NONE, 1'b0, X_RCL, 1'b0, X_LR, 1'b0, X_LC);
      7'd52: i = mk(OP_MUL, FC_NONE, 1'b0, X_RCR, 1'b0, X_RR, 1'b0, X_RC);
      7'd53: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_RCL, 1'b0, X_LR);
      7'd54: i = mk(OP_MUL, FC_NONE, 1'b0, X_T2, 1'b0, X_RCR, 1'b0, X_RR);
      7'd55: i = mk(OP_ADD, FC_NONE, 1'b0, X_T1, 1'b0, X_T1, 1'b0, X_T2);
      7'd56: i = mk(OP_DIV, FC_P, 1'b0, X_RCLR, 1'b0, X_T1, 1'b0, X_SUM);
      7'd57: i = mk(OP_SUB, FC_NONE, 1'b0, X_DU, 1'b0, X_LU, 1'b0, X_RU);
      7'd58: i = mk(OP_MUL, FC_NONE, 1'b0, X_LIM, 1'b0, X_RA, 1'b0, X_DU);
      7'd59: i = mk(OP_MAX0, FC_NONE, 1'b0, X_LIM, 1'b0, X_LIM, 1'b0, X_ZERO);
      7'd60: i = mk(OP_ADD, FC_NONE, 1'b0, X_T1, 1'b0, X_LIM, 1'b0, X_LIM);
      7'd61: i = mk(OP_ADD, FC_NONE, 1'b0, X_LIM, 1'b0, X_T1, 1'b0, X_LIM);
      7'd62: i = mk(OP_MIN, FC_NONE, 1'b0, X_LIM, 1'b0, X_LIM, 1'b0, X_RCLR);
      7'd63: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_LIM, 1'b0, X_DU);
      7'd64: i = mk(OP_SUB, FC_NONE, 1'b0, X_T2, 1'b0, X_RCR, 1'b0, X_RCL);
      7'd65: i = mk(OP_MUL, FC_NONE, 1'b0, X_T2, 1'b0, X_SS, 1'b0, X_T2);
      7'd66: i = mk(OP_ADD, FC_NONE, 1'b0, X_T1, 1'b0, X_T1, 1'b0, X_T2);
      7'd67: i = mk(OP_HALF, FC_NONE, 1'b0, X_T1, 1'b0, X_T1, 1'b0, X_ZERO);
      7'd68: i = mk(OP_ADD, FC_NONE, 1'b0, X_T2, 1'b0, X_LP, 1'b0, X_RP);
      7'd69: i = mk(OP_HALF, FC_NONE, 1'b0, X_T2, 1'b0, X_T2, 1'b0, X_ZERO);
      7'd70: i = mk(OP_ADD, FC_NONE, 1'b0, X_PST, 1'b0, X_T2, 1'b0, X_T1);
      7'd72: i = mk(OP_SUB, FC_NONE, 1'b0, X_T1, 1'b0, X_LS, 1'b0, X_LU);
      7'd73: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_LR, 1'b0, X_T1);
      7'd74: i = mk(OP_SUB, FC_NONE, 1'b0, X_T2, 1'b0, X_SS, 1'b0, X_LU);
      7'd75: i = mk(OP_MUL, FC_NONE, 1'b0, X_T1, 1'b0, X_T1, 1'b0, X_T2);
      7'd76: i = mk(OP_ADD, FC_NONE, 1'b0, X_PST, 1'b0, X_LP, 1'b0, X_T1);
      default: i = mk(OP_END, FC_NONE, 1'b0, X_ZERO, 1'b0, X_ZERO, 1'b0, X_ZERO);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

[design/hllc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hllc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/hllc_fifo.sv]
// Two-entry queue between the front and back parts.
`default_nettype none
module hllc_fifo
  import hllc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  q_entry_t      push_data,
  input  wire logic     pop,
  output logic          full,
  output logic          not_empty,
  output q_entry_t      head
);
  q_entry_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

[design/hllc_front.sv]
// Front part: accept items, hold the left state, queue right items with a left snapshot.
`default_nettype none
module hllc_front
  import hllc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  input  wire logic q_full,
  output logic      push,
  output q_entry_t  push_data
);
  fix_t l_density_r, l_pressure_r, l_energy_r, l_sound_r, l_vx_r, l_vy_r, l_vz_r;
  logic take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && in_item.side;

  always_comb begin
    push_data.rgt        = in_item;
    push_data.l_density  = l_density_r;
    push_data.l_pressure = l_pressure_r;
    push_data.l_energy   = l_energy_r;
    push_data.l_sound    = l_sound_r;
    push_data.l_vx       = l_vx_r;
    push_data.l_vy       = l_vy_r;
    push_data.l_vz       = l_vz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_density_r  <= '0;
      l_pressure_r <= '0;
      l_energy_r   <= '0;
      l_sound_r    <= '0;
      l_vx_r       <= '0;
      l_vy_r       <= '0;
      l_vz_r       <= '0;
    end else if (take && !in_item.side) begin
      l_density_r  <= in_item.density;
      l_pressure_r <= in_item.pressure;
      l_energy_r   <= in_item.total_energy;
      l_sound_r    <= in_item.sound_speed;
      l_vx_r       <= in_item.vel_x;
      l_vy_r       <= in_item.vel_y;
      l_vz_r       <= in_item.vel_z;
    end
  end
endmodule
`default_nettype wire

[design/hllc_mul.sv]
// Saturating fixed-point multiplier built from four 32x32 partial products.
`default_nettype none
module hllc_mul #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      result
);
  logic         busy_r;
  logic         done_r;
  logic [2:0]   cnt_r;
  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [127:0] acc_r;
  logic [127:0] pp_sh;
  logic [127:0] shifted;
  logic [31:0]  ah, bh;
  logic         over;

  assign done = done_r;

  always_comb begin
    ah = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
    bh = cnt_r[0] ? ub_r[63:32] : ub_r[31:0];
    case (sh_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
    shifted = acc_r >> FRAC_BITS;
    over    = (|shifted[127:64]) | shifted[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= a[63] ? 64'd0 - a : a;
      ub_r  <= b[63] ? 64'd0 - b : b;
      neg_r <= a[63] ^ b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_r <= {32'd0, ah} * {32'd0, bh};
        sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
        acc_r <= acc_r + pp_sh;
      end
      if (cnt_r == 3'd5) begin
        if (neg_r) begin
          result <= over ? 64'sh8000_0000_0000_0000 : 64'd0 - shifted[63:0];
        end else begin
          result <= over ? 64'sh7fff_ffff_ffff_ffff : shifted[63:0];
        end
      end
    end
  end
endmodule
`default_nettype wire

[design/hllc_div.sv]
// Saturating fixed-point divider, restoring, one quotient bit per cycle.
`default_nettype none
module hllc_div #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic                    fault,
  output logic signed [63:0]      result
);
  logic         busy_r;
  logic         zf_r;
  logic [7:0]   cnt_r;
  logic [127:0] num_r;
  logic [63:0]  d_r;
  logic [63:0]  r_r;
  logic [63:0]  q_r;
  logic         qhi_r;
  logic         neg_r;
  logic [64:0]  rs;
  logic         ge;
  logic         over;
  logic [63:0]  ua;

  always_comb begin
    ua   = a[63] ? 64'd0 - a : a;
    rs   = {r_r, num_r[127]};
    ge   = rs >= {1'b0, d_r};
    over = qhi_r | q_r[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= 8'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 8'd0;
      end else if (busy_r) begin
        if (zf_r || cnt_r == 8'd128) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
        cnt_r <= cnt_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zf_r  <= (b == 64'sd0);
      num_r <= {64'd0, ua} << FRAC_BITS;
      d_r   <= b[63] ? 64'd0 - b : b;
      r_r   <= '0;
      q_r   <= '0;
      qhi_r <= 1'b0;
      neg_r <= a[63] ^ b[63];
    end else if (busy_r) begin
      if (zf_r) begin
        fault  <= 1'b1;
        result <= '0;
      end else if (cnt_r == 8'd128) begin
        fault <= 1'b0;
        if (neg_r) begin
          result <= over ? 64'sh8000_0000_0000_0000 : 64'd0 - q_r;
        end else begin
          result <= over ? 64'sh7fff_ffff_ffff_ffff : q_r;
        end
      end else begin
        num_r <= {num_r[126:0], 1'b0};
        r_r   <= ge ? 64'(rs - {1'b0, d_r}) : rs[63:0];
        q_r   <= {q_r[62:0], ge};
        qhi_r <= qhi_r | q_r[63];
      end
    end
  end
endmodule
`default_nettype wire

[design/hllc_back.sv]
// Back part: microprogrammed sequencer over a register file with shared mul and div units.
`default_nettype none
module hllc_back
  import hllc_pkg::*;
#(
  parameter int DIMENSIONS = 3,
  parameter int FRAC_BITS  = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic limiter_enable,
  input  wire logic q_not_empty,
  input  q_entry_t  q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_FETCH  = 8'b0000_0100,
    S_EXEC   = 8'b0000_1000,
    S_WAIT   = 8'b0001_0000,
    S_GFETCH = 8'b0010_0000,
    S_GCAP   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  localparam logic Is2d = (DIMENSIONS == 2);
  localparam logic [4:0] LdLast = 5'd21;

  state_t     state_r;
  logic [6:0] pc_r;
  logic [4:0] ld_r;
  logic [2:0] g_r;
  logic [1:0] region_r;
  logic       fs_r, fr_r, fe_r, fp_r;
  logic       sl_np_r, sr_neg_r, ss_neg_r, ss_zero_r;
  out_item_t  res_r, out_r;
  logic       out_valid_r;

  instr_t     ins;
  logic       we;
  logic [5:0] waddr, raddr_a, raddr_b, gaddr;
  fix_t       wdata, rdata_a, rdata_b, alu, load_val;
  logic       right_k, star, mul_start, div_start, mul_done, div_done, div_fault;
  fix_t       mul_res, div_res;
  logic [1:0] region_calc;
  logic       zero_g;
  fix_t       cap;

  function automatic fix_t sat_add(fix_t x, fix_t y);
    logic [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end
    return s[63:0];
  endfunction

  function automatic fix_t sat_sub(fix_t x, fix_t y);
    logic [64:0] s;
    s = {x[63], x} - {y[63], y};
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end
    return s[63:0];
  endfunction

  assign ins       = prog(pc_r);
  assign right_k   = (region_r == REG_RSTAR);
  assign star      = (region_r == REG_LSTAR) || (region_r == REG_RSTAR);
  assign mul_start = (state_r == S_EXEC) && (ins.op == OP_MUL);
  assign div_start = (state_r == S_EXEC) && (ins.op == OP_DIV);
  assign q_pop     = (state_r == S_LOAD) && (ld_r == LdLast);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  hllc_ram #(.WIDTH(64), .DEPTH(64)) u_rf_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_a), .rdata(rdata_a)
  );
  hllc_ram #(.WIDTH(64), .DEPTH(64)) u_rf_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr_b), .rdata(rdata_b)
  );

  hllc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(rdata_a), .b(rdata_b),
    .done(mul_done), .result(mul_res)
  );
  hllc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(rdata_a), .b(rdata_b),
    .done(div_done), .fault(div_fault), .result(div_res)
  );

  always_comb begin
    case (ld_r)
      5'd1:  load_val = q_head.l_density;
      5'd2:  load_val = q_head.l_pressure;
      5'd3:  load_val = q_head.l_energy;
      5'd4:  load_val = q_head.l_sound;
      5'd5:  load_val = q_head.l_vx;
      5'd6:  load_val = q_head.l_vy;
      5'd7:  load_val = q_head.l_vz;
      5'd10: load_val = q_head.rgt.density;
      5'd11: load_val = q_head.rgt.pressure;
      5'd12: load_val = q_head.rgt.total_energy;
      5'd13: load_val = q_head.rgt.sound_speed;
      5'd14: load_val = q_head.rgt.vel_x;
      5'd15: load_val = q_head.rgt.vel_y;
      5'd16: load_val = q_head.rgt.vel_z;
      5'd19: load_val = q_head.rgt.normal_x;
      5'd20: load_val = q_head.rgt.normal_y;
      5'd21: load_val = q_head.rgt.normal_z;
      default: load_val = '0;
    endcase
  end

  always_comb begin
    case (ins.op)
      OP_ADD:  alu = sat_add(rdata_a, rdata_b);
      OP_SUB:  alu = sat_sub(rdata_a, rdata_b);
      OP_HALF: alu = $signed(rdata_a + {63'd0, rdata_a[63]}) >>> 1;
      OP_MAX0: alu = rdata_a[63] ? 64'sd0 : rdata_a;
      OP_MIN:  alu = (rdata_b < rdata_a) ? rdata_b : rdata_a;
      default: alu = rdata_a;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ins.dst;
    wdata = alu;
    if (state_r == S_LOAD) begin
      we    = 1'b1;
      waddr = {1'b0, ld_r};
      wdata = load_val;
    end else if (state_r == S_EXEC) begin
      we = !(ins.op == OP_MUL || ins.op == OP_DIV);
    end else if (state_r == S_WAIT) begin
      if (ins.op == OP_MUL) begin
        we    = mul_done;
        wdata = mul_res;
      end else begin
        we    = div_done;
        wdata = div_res;
      end
    end
  end

  always_comb begin
    if (star) begin
      case (g_r)
        3'd0:    gaddr = X_RHO;
        3'd1:    gaddr = X_VS0;
        3'd2:    gaddr = X_VS1;
        3'd3:    gaddr = X_VS2;
        3'd4:    gaddr = X_PST;
        default: gaddr = X_EST;
      endcase
    end else begin
      case (g_r)
        3'd0:    gaddr = X_LR;
        3'd1:    gaddr = X_LV0;
        3'd2:    gaddr = X_LV1;
        3'd3:    gaddr = X_LV2;
        3'd4:    gaddr = X_LP;
        default: gaddr = X_LE;
      endcase
      if (region_r == REG_RIGHT) begin
        gaddr = gaddr + K_OFS;
      end
    end
    raddr_a = (state_r == S_GFETCH) ? gaddr : ((ins.ka && right_k) ? ins.a + K_OFS : ins.a);
    raddr_b = (ins.kb && right_k) ? ins.b + K_OFS : ins.b;
  end

  always_comb begin
    region_calc = REG_LEFT;
    if (sl_np_r && !ss_neg_r) begin
      region_calc = REG_LSTAR;
    end
    if ((ss_neg_r || ss_zero_r) && !sr_neg_r) begin
      region_calc = REG_RSTAR;
    end
    if (sr_neg_r) begin
      region_calc = REG_RIGHT;
    end
    zero_g = (g_r == 3'd3) && Is2d;
    if (star) begin
      zero_g = zero_g || fs_r || (fr_r && (g_r == 3'd0 || g_r == 3'd5)) ||
               (fe_r && g_r == 3'd5) || (fp_r && g_r == 3'd4);
    end
    cap = zero_g ? 64'sd0 : rdata_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      ld_r        <= '0;
      g_r         <= '0;
      region_r    <= REG_LEFT;
      fs_r        <= 1'b0;
      fr_r        <= 1'b0;
      fe_r        <= 1'b0;
      fp_r        <= 1'b0;
      sl_np_r     <= 1'b0;
      sr_neg_r    <= 1'b0;
      ss_neg_r    <= 1'b0;
      ss_zero_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (we && state_r != S_LOAD) begin
        if (waddr == X_LS) begin
          sl_np_r <= wdata[63] || (wdata == 64'sd0);
        end
        if (waddr == X_RS) begin
          sr_neg_r <= wdata[63];
        end
        if (waddr == X_SS) begin
          ss_neg_r  <= wdata[63];
          ss_zero_r <= (wdata == 64'sd0);
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            fs_r     <= 1'b0;
            fr_r     <= 1'b0;
            fe_r     <= 1'b0;
            fp_r     <= 1'b0;
            region_r <= REG_LEFT;
            ld_r     <= '0;
            state_r  <= S_LOAD;
          end
        end
        S_LOAD: begin
          ld_r <= ld_r + 5'd1;
          if (ld_r == LdLast) begin
            pc_r    <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (ins.op == OP_END) begin
            if (pc_r == PC_END_A) begin
              region_r <= region_calc;
              g_r      <= '0;
              if ((region_calc == REG_LSTAR || region_calc == REG_RSTAR) && !fs_r) begin
                pc_r    <= PC_STAR;
                state_r <= S_FETCH;
              end else begin
                state_r <= S_GFETCH;
              end
            end else if (pc_r == PC_END_B) begin
              pc_r <= limiter_enable ? PC_LIM : PC_PLAIN;
            end else begin
              g_r     <= '0;
              state_r <= S_GFETCH;
            end
          end else if (ins.d3 && Is2d) begin
            pc_r <= pc_r + 7'd1;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ins.op == OP_MUL || ins.op == OP_DIV) begin
            state_r <= S_WAIT;
          end else begin
            pc_r    <= pc_r + 7'd1;
            state_r <= S_FETCH;
          end
        end
        S_WAIT: begin
          if ((ins.op == OP_MUL && mul_done) || (ins.op == OP_DIV && div_done)) begin
            if (ins.op == OP_DIV && div_fault) begin
              case (ins.fc)
                FC_S:    fs_r <= 1'b1;
                FC_R:    fr_r <= 1'b1;
                FC_E:    fe_r <= 1'b1;
                FC_P:    fp_r <= 1'b1;
                default: fs_r <= fs_r;
              endcase
            end
            pc_r    <= pc_r + 7'd1;
            state_r <= S_FETCH;
          end
        end
        S_GFETCH: begin
          state_r <= S_GCAP;
        end
        S_GCAP: begin
          case (g_r)
            3'd0:    res_r.star_density  <= cap;
            3'd1:    res_r.star_vel_x    <= cap;
            3'd2:    res_r.star_vel_y    <= cap;
            3'd3:    res_r.star_vel_z    <= cap;
            3'd4:    res_r.star_pressure <= cap;
            default: res_r.star_energy   <= cap;
          endcase
          if (g_r == 3'd5) begin
            state_r <= S_DONE;
          end else begin
            g_r     <= g_r + 3'd1;
            state_r <= S_GFETCH;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= {res_r[$bits(out_item_t)-1:3], region_r,
                            star && (fs_r || fr_r || fe_r || fp_r)};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/hllc_compressible_interface_state.sv]
// A left item only updates the held left state and gives no result; a right item
// gives one result after it leaves the queue, with more work for a plain star region
// than for an outer region and more again with the limiter on.
// The sequencer finishes one right item before it loads the next, using one to seven
// divisions per item; the divider and multiplier are both shared by the sequencer.
// Reset: synchronous active-low rst_n clears the left state, limiter and queue.
`default_nettype none
module hllc_compressible_interface_state
  import hllc_pkg::*;
#(
  parameter int DIMENSIONS = 3,
  parameter int FRAC_BITS  = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_limiter_enable
);
  logic     limiter_r;
  logic     q_full, q_not_empty, push, pop;
  q_entry_t push_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limiter_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      limiter_r <= cfg_limiter_enable;
    end
  end

  hllc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_full(q_full), .push(push), .push_data(push_data)
  );

  hllc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .pop(pop),
    .full(q_full), .not_empty(q_not_empty), .head(q_head)
  );

  hllc_back #(.DIMENSIONS(DIMENSIONS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .limiter_enable(limiter_r),
    .q_not_empty(q_not_empty), .q_head(q_head), .q_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );
endmodule
`default_nettype wire
